/* sv/rcbh_pkg.sv */
// ----------------------------------------------------------------------------
// rcbh_pkg: shared types and constants
// Payload structs, request/action codes, phase encoding and the command and
// status bundles between the sequencer controller and its datapath.
// ----------------------------------------------------------------------------
package rcbh_pkg;

    localparam int NUM_CHANNELS = 12;
    localparam int BIND_REPEATS = 6;
    localparam int STORE_BYTES  = 16;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               bind_request;
        logic [3:0]         channel_index;
        logic signed [11:0] channel_value;
        logic               rx_complete;
        logic [7:0]         rx_length;
        logic [7:0]         rx_count;
        logic [63:0]        rx_bytes_low;
        logic [55:0]        rx_bytes_high;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [6:0]  rf_channel;
        logic        transmit_mode;
        logic [4:0]  packet_length;
        logic [63:0] packet_low;
        logic [63:0] packet_high;
        logic [15:0] next_delay;
        logic        code_update;
        logic [4:0]  code_index;
        logic [15:0] crc_seed;
        logic        binding;
    } out_item_t;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    // radio actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_SEND = 2'd1;
    localparam logic [1:0] ACT_RECV = 2'd2;
    localparam logic [1:0] ACT_TUNE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_RADIO_ID    = 3'd0;
    localparam logic [2:0] CFG_RX_NUMBER   = 3'd1;
    localparam logic [2:0] CFG_HOP_FIRST   = 3'd2;
    localparam logic [2:0] CFG_HOP_SECOND  = 3'd3;
    localparam logic [2:0] CFG_HOP_THIRD   = 3'd4;
    localparam logic [2:0] CFG_AUTO_BIND   = 3'd5;

    // sequencer phases
    typedef logic [3:0] phase_t;
    localparam phase_t PH_BIND      = 4'd0;
    localparam phase_t PH_BIND_SEND = 4'd1;
    localparam phase_t PH_LISTEN    = 4'd2;
    localparam phase_t PH_CHECK     = 4'd3;
    localparam phase_t PH_ACK       = 4'd4;
    localparam phase_t PH_CHANSEL   = 4'(4 + BIND_REPEATS);
    localparam phase_t PH_HOP1      = 4'(5 + BIND_REPEATS);
    localparam phase_t PH_HOP4      = 4'(8 + BIND_REPEATS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_EVAL,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic       latch_in;
        logic       pack_en;
        logic [3:0] pack_idx;
        logic       eval;
        phase_t     phase;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       bind_start;
        logic       check_ok;
    } dp_status_t;

endpackage

/* sv/rcbh_ctrl.sv */
// ----------------------------------------------------------------------------
// rcbh_ctrl: sequencer controller
// Handshake state machine, channel packing counter and the link phase.
// ----------------------------------------------------------------------------
module rcbh_ctrl
    import rcbh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        need_pack;

    assign need_pack = (status.req_type == REQ_TICK)
                       && ((phase_reg == PH_CHANSEL) || (phase_reg == PH_HOP1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_CHANSEL;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_PREP;
            ST_PREP:
                if (!need_pack || (cnt_reg == 4'(NUM_CHANNELS - 1)))
                    state_next = ST_EVAL;
            ST_EVAL:
                state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // packing counter and link phase
    always_comb
    begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (state_reg == ST_IDLE)
            cnt_next = '0;
        else if (state_reg == ST_PREP)
            cnt_next = cnt_reg + 4'd1;

        if (state_reg == ST_EVAL)
        begin
            if (status.req_type == REQ_START)
                phase_next = status.bind_start ? PH_BIND : PH_CHANSEL;
            else if (status.req_type == REQ_TICK)
            begin
                priority if (phase_reg == PH_BIND || phase_reg == PH_BIND_SEND)
                    phase_next = PH_LISTEN;
                else if (phase_reg == PH_LISTEN)
                    phase_next = PH_CHECK;
                else if (phase_reg == PH_CHECK)
                    phase_next = status.check_ok ? PH_ACK : PH_BIND_SEND;
                else if (phase_reg >= PH_ACK && phase_reg < PH_CHANSEL)
                    phase_next = phase_reg + 4'd1;
                else if (phase_reg == PH_CHANSEL)
                    phase_next = PH_HOP1 + 4'd1;
                else if (phase_reg == PH_HOP4)
                    phase_next = PH_HOP1;
                else if (phase_reg > PH_CHANSEL && phase_reg < PH_HOP4)
                    phase_next = phase_reg + 4'd1;
                else
                    phase_next = phase_reg;
            end
        end
    end

    // outputs
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        out_valid    = (state_reg == ST_OUT);
        cmd.latch_in = (state_reg == ST_IDLE) && in_valid;
        cmd.pack_en  = (state_reg == ST_PREP) && need_pack;
        cmd.pack_idx = cnt_reg;
        cmd.eval     = (state_reg == ST_EVAL);
        cmd.phase    = phase_reg;
    end

endmodule

/* sv/rcbh_datapath.sv */
// ----------------------------------------------------------------------------
// rcbh_datapath: sequencer datapath
// Configuration registers, channel values, packet store, code setup and the
// result register.
// ----------------------------------------------------------------------------
module rcbh_datapath
    import rcbh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  in_item_t   in_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_item_t  out_data
);

    logic [31:0] radio_id_reg;
    logic [7:0]  rx_number_reg;
    logic [6:0]  hop_first_reg;
    logic [6:0]  hop_second_reg;
    logic [6:0]  hop_third_reg;
    logic        auto_bind_reg;

    in_item_t    item_reg;
    out_item_t   out_reg, out_next;
    logic [11:0] chan_reg [NUM_CHANNELS];
    logic [7:0]  store_reg [STORE_BYTES];
    logic [7:0]  store_next [STORE_BYTES];

    logic [7:0]  id_b [4];
    logic [7:0]  rx_b [15];
    logic        rx_full;

    // channel packing
    logic signed [11:0] pk_val;
    logic signed [11:0] pk_half;
    logic signed [11:0] pk_clamp;
    logic signed [11:0] pk_off;
    logic [9:0]         pk_v10;
    logic [3:0]         pk_hi_byte;

    // code setup
    logic [7:0]  sum8;
    logic [12:0] quot_prod;
    logic [4:0]  quot;
    logic [8:0]  code_rem;
    logic [7:0]  seed_lo;
    logic [7:0]  seed_hi;
    logic [1:0]  slot;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            id_b[k] = radio_id_reg[8*k +: 8];
        for (int k = 0; k < 8; k++)
            rx_b[k] = item_reg.rx_bytes_low[8*k +: 8];
        for (int k = 0; k < 7; k++)
            rx_b[k + 8] = item_reg.rx_bytes_high[8*k +: 8];
    end

    assign rx_full = item_reg.rx_complete && (item_reg.rx_length == 8'h0f)
                     && (item_reg.rx_count == 8'h0f);

    assign status.req_type   = item_reg.req_type;
    assign status.bind_start = item_reg.bind_request || auto_bind_reg;
    assign status.check_ok   = rx_full && (rx_b[0] == 8'h03)
                               && (rx_b[3] == id_b[0]) && (rx_b[4] == id_b[1])
                               && (rx_b[5] == id_b[2]) && (rx_b[6] == id_b[3])
                               && (rx_b[7] == rx_number_reg) && (rx_b[8] == 8'hfe);

    // halve toward zero, clamp to +-511, offset to 0..1022
    always_comb
    begin
        pk_val   = $signed(chan_reg[cmd.pack_idx]);
        pk_half  = (pk_val + $signed({11'b0, pk_val[11]})) >>> 1;
        if (pk_half < -12'sd511)
            pk_clamp = -12'sd511;
        else if (pk_half > 12'sd511)
            pk_clamp = 12'sd511;
        else
            pk_clamp = pk_half;
        pk_off     = pk_clamp + 12'sd511;
        pk_v10     = pk_off[9:0];
        pk_hi_byte = 4'd13 + {2'b00, cmd.pack_idx[3:2]};
    end

    // code index = (sum - 0xfe) mod 19, via reciprocal multiply
    always_comb
    begin
        sum8      = id_b[0] + id_b[1] + id_b[2] + id_b[3] - 8'hfe;
        quot_prod = 13'(sum8) * 13'd27;
        quot      = {1'b0, quot_prod[12:9]};
        code_rem  = {1'b0, sum8} - (9'(quot) * 9'd19);
        seed_lo   = id_b[1] - rx_number_reg + 8'hfe;
        seed_hi   = id_b[2] + id_b[3] - rx_number_reg + 8'hfe;
        slot      = (cmd.phase == PH_CHANSEL) ? 2'd0 : 2'(cmd.phase - PH_HOP1);
    end

    // packet store and result
    always_comb
    begin
        for (int k = 0; k < STORE_BYTES; k++)
            store_next[k] = store_reg[k];
        out_next = '0;

        if (cmd.pack_en)
        begin
            store_next[0] = 8'haa;
            store_next[cmd.pack_idx + 4'd1] = pk_v10[7:0];
            store_next[pk_hi_byte][{cmd.pack_idx[1:0], 1'b0} +: 2] = pk_v10[9:8];
        end

        if (cmd.eval)
        begin
            if (item_reg.req_type == REQ_START)
                out_next.binding = status.bind_start;
            else if (item_reg.req_type == REQ_TICK)
            begin
                priority if (cmd.phase == PH_BIND || cmd.phase == PH_BIND_SEND)
                begin
                    if (cmd.phase == PH_BIND)
                    begin
                        out_next.code_update = 1'b1;
                        out_next.code_index  = 5'd19;
                        store_next[0] = 8'h01;
                        store_next[1] = 8'h01;
                        store_next[2] = 8'h56;
                        store_next[3] = id_b[0];
                        store_next[4] = id_b[1];
                        store_next[5] = id_b[2];
                        store_next[6] = id_b[3];
                        store_next[7] = rx_number_reg;
                        store_next[8] = 8'hfe;
                    end
                    out_next.action        = ACT_SEND;
                    out_next.rf_channel    = 7'h52;
                    out_next.transmit_mode = 1'b1;
                    out_next.packet_length = 5'd9;
                    out_next.next_delay    = 16'd6000;
                    out_next.binding       = 1'b1;
                end
                else if (cmd.phase == PH_LISTEN)
                begin
                    out_next.action     = ACT_RECV;
                    out_next.rf_channel = 7'h53;
                    out_next.next_delay = 16'd60000;
                    out_next.binding    = 1'b1;
                end
                else if (cmd.phase == PH_CHECK)
                begin
                    out_next.binding = 1'b1;
                    if (rx_full)
                        for (int k = 0; k < 15; k++)
                            store_next[k] = rx_b[k];
                    if (status.check_ok)
                    begin
                        store_next[0]          = 8'h05;
                        out_next.action        = ACT_TUNE;
                        out_next.rf_channel    = 7'h54;
                        out_next.transmit_mode = 1'b1;
                        out_next.next_delay    = 16'd4000;
                    end
                    else
                        out_next.next_delay = 16'd1000;
                end
                else if (cmd.phase >= PH_ACK && cmd.phase < PH_CHANSEL)
                begin
                    out_next.action        = ACT_SEND;
                    out_next.rf_channel    = 7'h54;
                    out_next.transmit_mode = 1'b1;
                    out_next.packet_length = 5'd15;
                    out_next.next_delay    = 16'd60000;
                    out_next.binding       = 1'b1;
                end
                else if (cmd.phase >= PH_CHANSEL && cmd.phase <= PH_HOP4)
                begin
                    if (cmd.phase == PH_CHANSEL)
                    begin
                        out_next.code_update = 1'b1;
                        out_next.code_index  = code_rem[4:0];
                        out_next.crc_seed    = {seed_hi, seed_lo};
                    end
                    unique case (slot)
                        2'd1:    out_next.rf_channel = hop_second_reg;
                        2'd2:    out_next.rf_channel = hop_third_reg;
                        default: out_next.rf_channel = hop_first_reg;
                    endcase
                    out_next.action        = ACT_SEND;
                    out_next.transmit_mode = 1'b1;
                    out_next.packet_length = 5'd16;
                    out_next.next_delay    = (cmd.phase == PH_HOP4) ? 16'd27800 : 16'd9100;
                end
                else
                    out_next.action = ACT_NONE;
            end

            // bytes beyond the packet length read as zero
            for (int k = 0; k < 8; k++)
            begin
                if (5'(k) < out_next.packet_length)
                    out_next.packet_low[8*k +: 8] = store_next[k];
                if (5'(k + 8) < out_next.packet_length)
                    out_next.packet_high[8*k +: 8] = store_next[k + 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radio_id_reg   <= '0;
            rx_number_reg  <= '0;
            hop_first_reg  <= 7'd8;
            hop_second_reg <= 7'd40;
            hop_third_reg  <= 7'd72;
            auto_bind_reg  <= 1'b0;
            for (int k = 0; k < NUM_CHANNELS; k++)
                chan_reg[k] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_RADIO_ID:   radio_id_reg   <= cfg_data;
                    CFG_RX_NUMBER:  rx_number_reg  <= cfg_data[7:0];
                    CFG_HOP_FIRST:  hop_first_reg  <= cfg_data[6:0];
                    CFG_HOP_SECOND: hop_second_reg <= cfg_data[6:0];
                    CFG_HOP_THIRD:  hop_third_reg  <= cfg_data[6:0];
                    CFG_AUTO_BIND:  auto_bind_reg  <= cfg_data[0];
                    default:        ;
                endcase
            end
            // drop writes to channels past the last one
            if (cmd.eval && (item_reg.req_type == REQ_WRITE)
                && (item_reg.channel_index < 4'(NUM_CHANNELS)))
                chan_reg[item_reg.channel_index] <= item_reg.channel_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
            item_reg <= in_data;
        if (cmd.eval)
            out_reg <= out_next;
        if (cmd.eval || cmd.pack_en)
            for (int k = 0; k < STORE_BYTES; k++)
                store_reg[k] <= store_next[k];
    end

    assign out_data = out_reg;

endmodule

/* sv/rc_radio_bind_and_hop_sequencer_top.sv */
// ----------------------------------------------------------------------------
// rc_radio_bind_and_hop_sequencer_top: radio bind and hop sequencer
// Transmitter-side sequencer producing one radio action per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one request per
//   transaction: a timer tick, a channel value write or a start.
//   Every request yields exactly one result transaction on the output
//   channel (out_valid/out_ready/out_data).
//   The user must write configuration registers through cfg_wr_en/cfg_index/
//   cfg_data only while the block is idle; the block does not enforce this.
//   A write takes effect at once. After acceptance a request passes through
//   the prepare and evaluate states before out_valid rises; ticks in the
//   channel select phase or on hop slot one stay in the prepare state while
//   the datapath packs the twelve channel values one per cycle.
//   One request is processed at a time: in_ready returns the cycle after
//   the result is taken.
//   A stalled receiver holds the result and blocks new requests.
//   Reset clears configuration to defaults, channel values to zero and
//   places the sequencer in the data channel select phase.
// ----------------------------------------------------------------------------
module rc_radio_bind_and_hop_sequencer_top
    import rcbh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rcbh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rcbh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: radio bind and hop sequencer testbench
// Drives ticks, channel writes and starts through the request channel,
// predicts every radio action in a scoreboard and compares each result as a
// whole. Covers bind handshakes (good and broken replies), data hopping and
// several register settings, with random gaps and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    import rcbh_pkg::*;

    class seq_scoreboard;
        logic [31:0] rid;
        logic [7:0]  rxnum;
        logic [6:0]  hop_a, hop_b, hop_c;
        logic        abind;
        phase_t      ph;
        logic [7:0]  store [16];
        logic [11:0] chval [12];
        out_item_t   pending [$];
        int          mism;

        function new();
            rid = '0;
            rxnum = '0;
            hop_a = 7'd8;
            hop_b = 7'd40;
            hop_c = 7'd72;
            abind = 1'b0;
            ph = PH_CHANSEL;
            mism = 0;
            foreach (store[i]) store[i] = '0;
            foreach (chval[i]) chval[i] = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                CFG_RADIO_ID:   rid = v;
                CFG_RX_NUMBER:  rxnum = v[7:0];
                CFG_HOP_FIRST:  hop_a = v[6:0];
                CFG_HOP_SECOND: hop_b = v[6:0];
                CFG_HOP_THIRD:  hop_c = v[6:0];
                CFG_AUTO_BIND:  abind = v[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] idb(int k);
            return rid[8*k +: 8];
        endfunction

        function void pack_channels();
            int v;
            store[0] = 8'haa;
            store[13] = '0;
            store[14] = '0;
            store[15] = '0;
            for (int i = 0; i < 12; i++)
            begin
                v = $signed(chval[i]);
                v = v / 2;
                if (v < -511) v = -511;
                if (v > 511) v = 511;
                v += 511;
                store[i+1] = v[7:0];
                store[13 + i/4] |= 8'(v[9:8]) << (2 * (i % 4));
            end
        endfunction

        // note an accepted request and queue the action it must produce
        function void note_request(in_item_t r);
            out_item_t e;
            phase_t p;
            logic ok;
            logic [7:0] s8;
            e = '0;
            if (r.req_type == REQ_WRITE)
            begin
                if (r.channel_index < 12) chval[r.channel_index] = r.channel_value;
            end
            else if (r.req_type == REQ_START)
            begin
                if (r.bind_request || abind)
                begin
                    ph = PH_BIND;
                    e.binding = 1'b1;
                end
                else ph = PH_CHANSEL;
            end
            else if (r.req_type == REQ_TICK)
            begin
                p = ph;
                if (p == PH_BIND)
                begin
                    e.code_update = 1'b1;
                    e.code_index = 5'd19;
                    store[0] = 8'h01;
                    store[1] = 8'h01;
                    store[2] = 8'h56;
                    for (int k = 0; k < 4; k++) store[3+k] = idb(k);
                    store[7] = rxnum;
                    store[8] = 8'hfe;
                    p = PH_BIND_SEND;
                end
                if (p == PH_BIND_SEND)
                begin
                    e.action = ACT_SEND; e.rf_channel = 7'h52; e.transmit_mode = 1'b1;
                    e.packet_length = 5'd9; e.next_delay = 16'd6000; e.binding = 1'b1;
                    ph = PH_LISTEN;
                end
                else if (p == PH_LISTEN)
                begin
                    e.action = ACT_RECV; e.rf_channel = 7'h53;
                    e.next_delay = 16'd60000; e.binding = 1'b1;
                    ph = PH_CHECK;
                end
                else if (p == PH_CHECK)
                begin
                    ok = 1'b0;
                    e.binding = 1'b1;
                    if (r.rx_complete && r.rx_length == 8'h0f && r.rx_count == 8'h0f)
                    begin
                        for (int i = 0; i < 8; i++) store[i] = r.rx_bytes_low[8*i +: 8];
                        for (int i = 0; i < 7; i++) store[8+i] = r.rx_bytes_high[8*i +: 8];
                        ok = store[0] == 8'h03 && store[3] == idb(0) && store[4] == idb(1)
                            && store[5] == idb(2) && store[6] == idb(3)
                            && store[7] == rxnum && store[8] == 8'hfe;
                    end
                    if (ok)
                    begin
                        store[0] = 8'h05;
                        e.action = ACT_TUNE; e.rf_channel = 7'h54; e.transmit_mode = 1'b1;
                        e.next_delay = 16'd4000;
                        ph = PH_ACK;
                    end
                    else
                    begin
                        e.next_delay = 16'd1000;
                        ph = PH_BIND_SEND;
                    end
                end
                else if (p >= PH_ACK && p < PH_CHANSEL)
                begin
                    e.action = ACT_SEND; e.rf_channel = 7'h54; e.transmit_mode = 1'b1;
                    e.packet_length = 5'd15; e.next_delay = 16'd60000; e.binding = 1'b1;
                    ph = p + 1'b1;
                end
                else if (p >= PH_CHANSEL && p <= PH_HOP4)
                begin
                    if (p == PH_CHANSEL)
                    begin
                        s8 = idb(0) + idb(1) + idb(2) + idb(3) - 8'hfe;
                        e.code_update = 1'b1;
                        e.code_index = 5'(s8 % 19);
                        e.crc_seed[7:0] = idb(1) - rxnum + 8'hfe;
                        e.crc_seed[15:8] = idb(2) + idb(3) - rxnum + 8'hfe;
                        p = PH_HOP1;
                    end
                    if (p == PH_HOP1) pack_channels();
                    case (p - PH_HOP1)
                        1: e.rf_channel = hop_b;
                        2: e.rf_channel = hop_c;
                        default: e.rf_channel = hop_a;
                    endcase
                    e.action = ACT_SEND; e.transmit_mode = 1'b1; e.packet_length = 5'd16;
                    if (p == PH_HOP4)
                    begin
                        ph = PH_HOP1;
                        e.next_delay = 16'd27800;
                    end
                    else
                    begin
                        ph = p + 1'b1;
                        e.next_delay = 16'd9100;
                    end
                end
                for (int i = 0; i < 16; i++)
                    if (i < e.packet_length)
                    begin
                        if (i < 8) e.packet_low[8*i +: 8] = store[i];
                        else e.packet_high[8*(i-8) +: 8] = store[i];
                    end
            end
            pending.push_back(e);
        endfunction

        function void check_result(out_item_t a);
            out_item_t e;
            if (pending.size() == 0)
            begin
                mism++;
                if (mism <= 10) $display("unexpected result %p", a);
                return;
            end
            e = pending.pop_front();
            if (a !== e)
            begin
                mism++;
                if (mism <= 10) $display("result mismatch\n  exp %p\n  got %p", e, a);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;

    seq_scoreboard sb;
    bit          hold_off;

    rc_radio_bind_and_hop_sequencer_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // valid stays high after acceptance until a gap or an idle phase drops it
    task automatic send_request(in_item_t r, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function in_item_t noise();
        in_item_t r;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(in_item_t)-1:0];
        return r;
    endfunction

    function in_item_t tick();
        in_item_t r;
        r = noise();
        r.req_type = REQ_TICK;
        return r;
    endfunction

    function in_item_t unknown_req();
        in_item_t r;
        r = noise();
        r.req_type = REQ_RSVD;
        return r;
    endfunction

    function in_item_t start_req(bit b);
        in_item_t r;
        r = noise();
        r.req_type = REQ_START;
        r.bind_request = b;
        return r;
    endfunction

    function in_item_t chan_write(logic [3:0] idx, logic [11:0] v);
        in_item_t r;
        r = noise();
        r.req_type = REQ_WRITE;
        r.channel_index = idx;
        r.channel_value = v;
        return r;
    endfunction

    // reply that passes the echo check unless a fault is injected
    function in_item_t bind_reply(int fault);
        in_item_t r;
        logic [119:0] b;
        r = tick();
        b = 120'({$urandom, $urandom, $urandom, $urandom});
        b[7:0] = 8'h03;
        b[55:24] = sb.rid;
        b[63:56] = sb.rxnum;
        b[71:64] = 8'hfe;
        r.rx_complete = 1'b1;
        r.rx_length = 8'h0f;
        r.rx_count = 8'h0f;
        case (fault)
            1: r.rx_complete = 1'b0;
            2: r.rx_length = 8'($urandom_range(0, 14));
            3: r.rx_count = 8'($urandom_range(16, 255));
            4: b[7:0] = 8'($urandom_range(4, 255));
            5: b[8*$urandom_range(3, 8) +: 8] ^= 8'(1 << $urandom_range(0, 7));
            default: ;
        endcase
        r.rx_bytes_low = b[63:0];
        r.rx_bytes_high = b[119:64];
        return r;
    endfunction

    task automatic bind_sequence(bit gaps);
        int f;
        send_request(start_req(1'b1), gaps);
        send_request(tick(), gaps);
        send_request(tick(), gaps);
        // up to two broken replies, then a final reply that is broken one time in five
        repeat ($urandom_range(0, 2))
        begin
            send_request(bind_reply($urandom_range(1, 5)), gaps);
            send_request(tick(), gaps);
            send_request(tick(), gaps);
        end
        f = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
        send_request(bind_reply(f), gaps);
        repeat ($urandom_range(2, 9)) send_request(tick(), gaps);
    endtask

    task automatic random_traffic(int n);
        int k;
        int c;
        k = 0;
        while (k < n)
        begin
            c = $urandom_range(0, 99);
            if (c < 8)
            begin
                bind_sequence(1'b1);
                k += 12;
            end
            else if (c < 10)
            begin
                send_request(start_req(1'b0), 1'b1);
                k++;
            end
            else if (c < 35)
            begin
                send_request(chan_write(4'($urandom_range(0, 15)), 12'($urandom)), 1'b1);
                k++;
            end
            else if (c < 37)
            begin
                send_request(noise(), 1'b1);
                k++;
            end
            else
            begin
                send_request(tick(), 1'b1);
                k++;
            end
        end
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            g = gap_len();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        hold_off = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset defaults, extremes of channel values, bad index, unknown request
        send_request(tick(), 1'b0);
        send_request(chan_write(4'd0, 12'h800), 1'b0);
        send_request(chan_write(4'd1, 12'h7ff), 1'b0);
        send_request(chan_write(4'd2, 12'hfff), 1'b0);
        send_request(chan_write(4'd3, 12'h001), 1'b0);
        send_request(chan_write(4'd11, 12'h3ff), 1'b0);
        send_request(chan_write(4'd12, 12'h123), 1'b0);
        send_request(chan_write(4'd15, 12'h7ff), 1'b0);
        send_request(unknown_req(), 1'b0);
        repeat (5) send_request(tick(), 1'b0);
        send_request(start_req(1'b0), 1'b0);
        send_request(tick(), 1'b0);
        wait_idle();

        write_reg(CFG_RADIO_ID, 32'hffffffff);
        write_reg(CFG_RX_NUMBER, 32'hff);
        write_reg(CFG_HOP_FIRST, 32'd77);
        write_reg(CFG_HOP_SECOND, 32'd8);
        write_reg(CFG_HOP_THIRD, 32'h7f);
        write_reg(CFG_AUTO_BIND, 32'd0);
        bind_sequence(1'b0);
        // long output stall while requests keep coming
        hold_off = 1;
        repeat (10) send_request(tick(), 1'b0);
        random_traffic(500);
        wait_idle();

        for (int s = 0; s < 3; s++)
        begin
            write_reg(CFG_RADIO_ID, (s == 0) ? 32'h0 : $urandom);
            write_reg(CFG_RX_NUMBER, (s == 0) ? 32'h0 : $urandom_range(0, 255));
            write_reg(CFG_HOP_FIRST, $urandom_range(8, 77));
            write_reg(CFG_HOP_SECOND, (s == 0) ? 32'd0 : $urandom_range(8, 77));
            write_reg(CFG_HOP_THIRD, $urandom_range(8, 77));
            write_reg(CFG_AUTO_BIND, 32'(s == 1));
            random_traffic(500);
            wait_idle();
        end

        if (sb.mism == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
